// ===== sv/sct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg: sleep countdown timer shared definitions
// Types, codes and helper functions used by the timer core and its channels.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int unsigned SEC_W   = 63;
    localparam int unsigned ADDR_W  = 3;

    localparam logic [SEC_W-1:0] MIN_STEP             = 63'd30;
    localparam logic [7:0]       CHECK_INTERVAL_RESET = 8'd5;
    localparam logic [0:0]       REG_CHECK_INTERVAL   = 1'b0;

    localparam logic [1:0] CMD_SET     = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_OUTCOME = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [1:0] MODE_MEM     = 2'd0;
    localparam logic [1:0] MODE_IDLE    = 2'd1;
    localparam logic [1:0] MODE_STANDBY = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_COUNT = 3'b010,
        PH_SLEEP = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [SEC_W-1:0] countdown;
        logic [SEC_W-1:0] last_clock;
        logic [1:0]       mode_index;
        logic             awaiting;
    } state_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [SEC_W-1:0] set_seconds;
        logic [SEC_W-1:0] now_seconds;
        logic             sleep_failed;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             timer_active;
        logic [SEC_W-1:0] remaining_seconds;
        logic             sleep_request;
        logic [1:0]       sleep_mode;
        logic             all_failed;
    } out_t;

    // x mod 30 from x mod 15 (nibble sum, since 16 = 1 mod 15) and x mod 2
    function automatic logic [4:0] mod30(input logic [SEC_W-1:0] x);
        logic [63:0] xe;
        logic [6:0]  sum_lo;
        logic [6:0]  sum_hi;
        logic [7:0]  total;
        logic [4:0]  fold1;
        logic [3:0]  fold2;
        logic [3:0]  r15;
        xe     = {1'b0, x};
        sum_lo = '0;
        sum_hi = '0;
        for (int i = 0; i < 8; i++) begin
            sum_lo = sum_lo + {3'b000, xe[4*i +: 4]};
            sum_hi = sum_hi + {3'b000, xe[32 + 4*i +: 4]};
        end
        total = {1'b0, sum_lo} + {1'b0, sum_hi};
        fold1 = {1'b0, total[7:4]} + {1'b0, total[3:0]};
        fold2 = {3'b000, fold1[4]} + fold1[3:0];
        r15   = (fold2 == 4'd15) ? 4'd0 : fold2;
        return (r15[0] == x[0]) ? {1'b0, r15} : ({1'b0, r15} + 5'd15);
    endfunction

endpackage
`default_nettype wire

// ===== sv/sct_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sct_if: item and result channels
// Valid/ready channels that carry one command item or one result item.
// ----------------------------------------------------------------------------
interface sct_item_if;
    logic          valid;
    logic          ready;
    sct_pkg::in_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sct_result_if;
    logic          valid;
    logic          ready;
    sct_pkg::out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/sleep_countdown_timer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sleep_countdown_timer_unit: countdown to system sleep on wall-clock time
// Set, tick and sleep-outcome transactions drive a countdown that requests
// memory, idle and standby sleep in turn once it expires.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock cycle unless the result channel
// stalls, and returns exactly one result per transaction, in order. A
// transaction is captured in an input register, evaluated combinationally
// against the timer state, and the result lands in an output register, so a
// result is offered on the result channel from the clock edge right after the
// one that accepts its transaction when the result channel is not stalled.
// The output register lets the next transaction enter while a result waits.
// The check interval register (byte address 0, reset 5) is written over the
// APB port and must only be changed while no transaction is in flight.
module sleep_countdown_timer_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sct_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output      logic [31:0]                prdata,
    output      logic                       pready,
    sct_item_if.sink                        item,
    sct_result_if.source                    result
);

    logic [7:0]       check_interval_reg;
    sct_pkg::state_t  state_reg;
    sct_pkg::state_t  state_next;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    sct_pkg::in_t     s1_item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    sct_pkg::out_t    out_data_reg;
    sct_pkg::out_t    step_res;
    logic             out_free;
    logic             advance;
    logic             accept;
    logic             cfg_write;
    logic             ci_sel;

    assign pready    = 1'b1;
    assign ci_sel    = (paddr[2] == sct_pkg::REG_CHECK_INTERVAL);
    assign cfg_write = psel && penable && pwrite && pready && ci_sel;
    assign prdata    = ci_sel ? {24'd0, check_interval_reg} : 32'd0;

    assign out_free   = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || out_free;
    assign accept     = item.valid && item.ready;
    assign advance    = s1_valid_reg && out_free;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    sct_step u_step (
        .cur            (state_reg),
        .item           (s1_item_reg),
        .check_interval (check_interval_reg),
        .nxt            (state_next),
        .res            (step_res)
    );

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_interval_reg   <= sct_pkg::CHECK_INTERVAL_RESET;
            state_reg.phase      <= sct_pkg::PH_IDLE;
            state_reg.countdown  <= '0;
            state_reg.last_clock <= '0;
            state_reg.mode_index <= sct_pkg::MODE_MEM;
            state_reg.awaiting   <= 1'b0;
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                check_interval_reg <= pwdata[7:0];
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item.data;
        end
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sct_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sct_step: timer update for one item
// Computes the next timer state and the result from the current state,
// one registered item and the check interval.
// ----------------------------------------------------------------------------
module sct_step (
    input  var sct_pkg::state_t cur,
    input  var sct_pkg::in_t    item,
    input  var logic [7:0]      check_interval,
    output sct_pkg::state_t     nxt,
    output sct_pkg::out_t       res
);

    logic [sct_pkg::SEC_W-1:0] set_v;
    logic [sct_pkg::SEC_W:0]   diff;
    logic [sct_pkg::SEC_W-1:0] ivl;
    logic                      small_step;
    logic [sct_pkg::SEC_W-1:0] dec;

    assign set_v = item.set_seconds
                   - {{(sct_pkg::SEC_W-5){1'b0}}, sct_pkg::mod30(item.set_seconds)};
    assign diff  = {1'b0, item.now_seconds} - {1'b0, cur.last_clock};
    assign ivl   = {{(sct_pkg::SEC_W-8){1'b0}}, check_interval};
    assign small_step = diff[sct_pkg::SEC_W] || (diff[sct_pkg::SEC_W-1:0] < ivl);
    assign dec   = small_step ? ivl : diff[sct_pkg::SEC_W-1:0];

    always_comb
    begin
        nxt                   = cur;
        res.status            = sct_pkg::ST_IGNORED;
        res.sleep_request     = 1'b0;
        res.sleep_mode        = sct_pkg::MODE_MEM;
        res.all_failed        = 1'b0;
        case (item.command)
            sct_pkg::CMD_SET:
            begin
                if (set_v < sct_pkg::MIN_STEP)
                begin
                    res.status = sct_pkg::ST_REJECT;
                end
                else
                begin
                    res.status = sct_pkg::ST_OK;
                    if (cur.phase == sct_pkg::PH_IDLE)
                    begin
                        nxt.phase      = sct_pkg::PH_COUNT;
                        nxt.last_clock = item.now_seconds;
                        nxt.mode_index = sct_pkg::MODE_MEM;
                        nxt.awaiting   = 1'b0;
                    end
                    nxt.countdown = set_v;
                end
            end
            sct_pkg::CMD_TICK:
            begin
                unique case (cur.phase)
                    sct_pkg::PH_COUNT:
                    begin
                        res.status = sct_pkg::ST_OK;
                        if (dec >= cur.countdown)
                        begin
                            nxt.countdown     = '0;
                            nxt.phase         = sct_pkg::PH_SLEEP;
                            nxt.mode_index    = sct_pkg::MODE_MEM;
                            nxt.awaiting      = 1'b1;
                            res.sleep_request = 1'b1;
                        end
                        else
                        begin
                            nxt.countdown  = cur.countdown - dec;
                            nxt.last_clock = item.now_seconds;
                        end
                    end
                    sct_pkg::PH_SLEEP:
                    begin
                        if (!cur.awaiting)
                        begin
                            res.status        = sct_pkg::ST_OK;
                            nxt.awaiting      = 1'b1;
                            res.sleep_request = 1'b1;
                            res.sleep_mode    = cur.mode_index;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            sct_pkg::CMD_OUTCOME:
            begin
                if (cur.phase == sct_pkg::PH_SLEEP && cur.awaiting)
                begin
                    res.status     = sct_pkg::ST_OK;
                    res.sleep_mode = cur.mode_index;
                    nxt.awaiting   = 1'b0;
                    if (!item.sleep_failed)
                    begin
                        nxt.phase      = sct_pkg::PH_IDLE;
                        nxt.mode_index = sct_pkg::MODE_MEM;
                    end
                    else if (cur.mode_index >= sct_pkg::MODE_STANDBY)
                    begin
                        res.all_failed = 1'b1;
                        nxt.phase      = sct_pkg::PH_IDLE;
                        nxt.mode_index = sct_pkg::MODE_MEM;
                    end
                    else
                    begin
                        nxt.mode_index = cur.mode_index + 2'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.timer_active      = (nxt.phase != sct_pkg::PH_IDLE);
        res.remaining_seconds = (nxt.phase == sct_pkg::PH_COUNT) ? nxt.countdown : '0;
    end

endmodule
`default_nettype wire

// ===== test/tb_sleep_countdown_timer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sleep_countdown_timer_unit: self-checking bench for the sleep countdown
// Drives set, tick and outcome transactions through the item channel. Each
// accepted transaction runs through a behavioral copy of the timer, and every
// result is checked field by field against the oldest awaited result. Runs
// several check_interval settings, and mixes source gaps and sink stalls,
// including one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_sleep_countdown_timer_unit;

    localparam int unsigned SEC_W  = sct_pkg::SEC_W;
    localparam int unsigned ADDR_W = sct_pkg::ADDR_W;

    localparam int          RUN_LIMIT   = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_ITEMS = 320;
    localparam logic [SEC_W-1:0] SEC_MAX = '1;
    localparam logic [ADDR_W-1:0] INTERVAL_ADDR =
        ADDR_W'({sct_pkg::REG_CHECK_INTERVAL, 2'b00});

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    sct_item_if   item_ch ();
    sct_result_if result_ch ();

    sleep_countdown_timer_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    sct_pkg::in_t  cmd_queue[$];
    sct_pkg::out_t awaited_results[$];

    int mismatches = 0;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int sink_stall_pct = 0;
    logic hold_arm = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    logic [SEC_W-1:0] wall_clock;

    // timer copy
    logic [7:0]       tm_interval;
    sct_pkg::phase_t  tm_phase;
    logic [SEC_W-1:0] tm_countdown;
    logic [SEC_W-1:0] tm_last_clock;
    logic [1:0]       tm_mode;
    logic             tm_awaiting;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic sct_pkg::out_t timer_response(input sct_pkg::in_t cmd);
        sct_pkg::out_t    r;
        logic [SEC_W-1:0] rounded;
        logic [SEC_W-1:0] step;
        r = '0;
        r.status = sct_pkg::ST_IGNORED;
        case (cmd.command)
            sct_pkg::CMD_SET:
            begin
                rounded = cmd.set_seconds - (cmd.set_seconds % sct_pkg::MIN_STEP);
                if (rounded < sct_pkg::MIN_STEP)
                    r.status = sct_pkg::ST_REJECT;
                else
                begin
                    r.status = sct_pkg::ST_OK;
                    if (tm_phase == sct_pkg::PH_IDLE)
                    begin
                        tm_phase = sct_pkg::PH_COUNT;
                        tm_last_clock = cmd.now_seconds;
                        tm_mode = sct_pkg::MODE_MEM;
                        tm_awaiting = 1'b0;
                    end
                    tm_countdown = rounded;
                end
            end
            sct_pkg::CMD_TICK:
            begin
                if (tm_phase == sct_pkg::PH_COUNT)
                begin
                    r.status = sct_pkg::ST_OK;
                    if (cmd.now_seconds < tm_last_clock
                        || cmd.now_seconds - tm_last_clock < SEC_W'(tm_interval))
                        step = SEC_W'(tm_interval);
                    else
                        step = cmd.now_seconds - tm_last_clock;
                    if (step >= tm_countdown)
                    begin
                        tm_countdown = '0;
                        tm_phase = sct_pkg::PH_SLEEP;
                        tm_mode = sct_pkg::MODE_MEM;
                        tm_awaiting = 1'b1;
                        r.sleep_request = 1'b1;
                        r.sleep_mode = sct_pkg::MODE_MEM;
                    end
                    else
                    begin
                        tm_countdown = tm_countdown - step;
                        tm_last_clock = cmd.now_seconds;
                    end
                end
                else if (tm_phase == sct_pkg::PH_SLEEP && !tm_awaiting)
                begin
                    r.status = sct_pkg::ST_OK;
                    tm_awaiting = 1'b1;
                    r.sleep_request = 1'b1;
                    r.sleep_mode = tm_mode;
                end
            end
            sct_pkg::CMD_OUTCOME:
            begin
                if (tm_phase == sct_pkg::PH_SLEEP && tm_awaiting)
                begin
                    r.status = sct_pkg::ST_OK;
                    r.sleep_mode = tm_mode;
                    tm_awaiting = 1'b0;
                    if (!cmd.sleep_failed)
                    begin
                        tm_phase = sct_pkg::PH_IDLE;
                        tm_mode = sct_pkg::MODE_MEM;
                    end
                    else if (tm_mode >= sct_pkg::MODE_STANDBY)
                    begin
                        r.all_failed = 1'b1;
                        tm_phase = sct_pkg::PH_IDLE;
                        tm_mode = sct_pkg::MODE_MEM;
                    end
                    else
                        tm_mode = tm_mode + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
        r.timer_active = (tm_phase != sct_pkg::PH_IDLE);
        r.remaining_seconds = (tm_phase == sct_pkg::PH_COUNT) ? tm_countdown : '0;
        return r;
    endfunction

    function automatic logic [SEC_W-1:0] rand_seconds();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[SEC_W-1:0];
    endfunction

    function automatic void queue_cmd(input logic [1:0] command, input logic [SEC_W-1:0] secs,
                                      input logic [SEC_W-1:0] now, input logic failed);
        sct_pkg::in_t c;
        c.command = command;
        c.set_seconds = secs;
        c.now_seconds = now;
        c.sleep_failed = failed;
        cmd_queue.push_back(c);
    endfunction

    function automatic void check_field(input string name, input logic [SEC_W-1:0] want,
                                        input logic [SEC_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // one countdown life: set, a random run of ticks, then sleep attempts
    task automatic queue_session(inout int added);
        int               ticks;
        logic [SEC_W-1:0] secs;
        secs = ($urandom_range(15) == 0) ? rand_seconds() : SEC_W'($urandom_range(400));
        queue_cmd(sct_pkg::CMD_SET, secs, wall_clock, 1'($urandom_range(1)));
        ticks = $urandom_range(12, 1);
        for (int i = 0; i < ticks; i++)
        begin
            case ($urandom_range(9))
                0: wall_clock = rand_seconds();
                1: wall_clock = wall_clock - SEC_W'($urandom_range(50));
                default: wall_clock = wall_clock + SEC_W'($urandom_range(60));
            endcase
            queue_cmd(sct_pkg::CMD_TICK, rand_seconds(), wall_clock, 1'($urandom_range(1)));
            if ($urandom_range(7) == 0)
                queue_cmd(sct_pkg::CMD_SET, SEC_W'($urandom_range(300)), rand_seconds(),
                          1'($urandom_range(1)));
        end
        for (int i = 0; i < 3; i++)
        begin
            queue_cmd(sct_pkg::CMD_TICK, rand_seconds(), wall_clock, 1'($urandom_range(1)));
            queue_cmd(sct_pkg::CMD_OUTCOME, rand_seconds(), rand_seconds(),
                      ($urandom_range(3) != 0));
        end
        if ($urandom_range(4) == 0)
            queue_cmd(2'($urandom_range(3)), rand_seconds(), rand_seconds(),
                      1'($urandom_range(1)));
        added = added + ticks + 7;
    endtask

    task automatic write_interval(input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= INTERVAL_ADDR;
        pwdata <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tm_interval = value;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || item_ch.valid || awaited_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // source side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                awaited_results.push_back(timer_response(item_ch.data));
            if (!item_ch.valid || item_ch.ready)
            begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    item_ch.data <= cmd_queue.pop_front();
                    item_ch.valid <= 1'b1;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction with no result awaited");
                    mismatches++;
                end
                else
                begin
                    sct_pkg::out_t want;
                    want = awaited_results.pop_front();
                    check_field("status", SEC_W'(want.status), SEC_W'(result_ch.data.status));
                    check_field("timer_active", SEC_W'(want.timer_active),
                                SEC_W'(result_ch.data.timer_active));
                    check_field("remaining_seconds", want.remaining_seconds,
                                result_ch.data.remaining_seconds);
                    check_field("sleep_request", SEC_W'(want.sleep_request),
                                SEC_W'(result_ch.data.sleep_request));
                    check_field("sleep_mode", SEC_W'(want.sleep_mode),
                                SEC_W'(result_ch.data.sleep_mode));
                    check_field("all_failed", SEC_W'(want.all_failed),
                                SEC_W'(result_ch.data.all_failed));
                end
            end
            result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // long sink hold-off
    always @(posedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int added;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tm_interval = sct_pkg::CHECK_INTERVAL_RESET;
        tm_phase = sct_pkg::PH_IDLE;
        tm_countdown = '0;
        tm_last_clock = '0;
        tm_mode = sct_pkg::MODE_MEM;
        tm_awaiting = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1:
                begin
                    send_gap_pct = 52;
                    sink_stall_pct = 0;
                    write_interval(8'd255);
                end
                2:
                begin
                    send_gap_pct = 0;
                    sink_stall_pct = 52;
                    write_interval(8'd0);
                    hold_arm <= 1'b1;
                end
                3:
                begin
                    send_gap_pct = 22;
                    sink_stall_pct = 22;
                    write_interval(8'd1);
                end
                4:
                begin
                    send_gap_pct = 0;
                    sink_stall_pct = 0;
                    write_interval(8'($urandom_range(254, 2)));
                end
                default:
                begin
                    send_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase

            if (ph == 0)
            begin
                queue_cmd(sct_pkg::CMD_TICK, SEC_MAX, SEC_MAX, 1'b1);
                queue_cmd(sct_pkg::CMD_OUTCOME, '0, '0, 1'b1);
                queue_cmd(2'd3, SEC_MAX, SEC_MAX, 1'b0);
                queue_cmd(sct_pkg::CMD_SET, '0, 63'd10, 1'b0);
                queue_cmd(sct_pkg::CMD_SET, 63'd29, 63'd10, 1'b1);
                queue_cmd(sct_pkg::CMD_SET, 63'd59, 63'd100, 1'b0);
                queue_cmd(sct_pkg::CMD_SET, SEC_MAX, 63'd7, 1'b1);
                queue_cmd(sct_pkg::CMD_TICK, '0, 63'd100, 1'b0);
                queue_cmd(sct_pkg::CMD_TICK, SEC_MAX, 63'd50, 1'b1);
                queue_cmd(sct_pkg::CMD_TICK, '0, 63'd103, 1'b0);
                queue_cmd(sct_pkg::CMD_SET, 63'd60, '0, 1'b0);
                queue_cmd(sct_pkg::CMD_TICK, '0, SEC_MAX, 1'b0);
                queue_cmd(sct_pkg::CMD_TICK, '0, SEC_MAX, 1'b0);
                queue_cmd(sct_pkg::CMD_SET, 63'd90, 63'd5, 1'b0);
                queue_cmd(sct_pkg::CMD_OUTCOME, SEC_MAX, '0, 1'b1);
                queue_cmd(sct_pkg::CMD_OUTCOME, '0, '0, 1'b1);
                queue_cmd(sct_pkg::CMD_TICK, '0, '0, 1'b0);
                queue_cmd(sct_pkg::CMD_OUTCOME, '0, '0, 1'b1);
                queue_cmd(sct_pkg::CMD_TICK, '0, '0, 1'b1);
                queue_cmd(sct_pkg::CMD_OUTCOME, '0, SEC_MAX, 1'b1);
                queue_cmd(sct_pkg::CMD_SET, 63'd30, '0, 1'b0);
                queue_cmd(sct_pkg::CMD_TICK, '0, 63'd30, 1'b0);
                queue_cmd(sct_pkg::CMD_TICK, '0, 63'd31, 1'b0);
                queue_cmd(sct_pkg::CMD_OUTCOME, '0, '0, 1'b0);
                queue_cmd(sct_pkg::CMD_TICK, '0, 63'd40, 1'b0);
            end

            wall_clock = SEC_W'($urandom);
            added = 0;
            while (added < PHASE_ITEMS)
                queue_session(added);
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sct_pkg.sv
sv/sct_if.sv
sv/sct_step.sv
sv/sleep_countdown_timer_unit.sv
test/tb_sleep_countdown_timer_unit.sv
